// ===== hdl/prq_pkg.sv =====
// Shared types and constants for the priority ready queue.
// Depends on nothing; every other file in hdl imports it.
package prq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_ENQ   = 2'd0,
        REQ_DEQ   = 2'd1,
        REQ_PURGE = 2'd2
    } req_code_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } status_code_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] proc_handle;
        logic [7:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [7:0]               out_handle;
        logic [7:0]               out_priority;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     is_empty;
    } rsp_t;

    typedef struct packed {
        logic [7:0] handle;
        logic [7:0] prio;
    } entry_t;

endpackage

// ===== hdl/prq_entry_store.sv =====
// Entry memory of the priority ready queue: one write port, one registered read port.
// Depends on prq_pkg for the entry type and the depth.
module prq_entry_store (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [prq_pkg::IDX_W-1:0] rd_addr,
    output prq_pkg::entry_t           rd_data,
    input  logic                      wr_en,
    input  logic [prq_pkg::IDX_W-1:0] wr_addr,
    input  prq_pkg::entry_t           wr_data
);
    import prq_pkg::*;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/priority_ready_queue_unit.sv =====
// Top level of the priority ready queue: request/response handshakes, the
// scan and compaction sequencer, and the entry count. Depends on prq_pkg and
// prq_entry_store.
//
//   Channel  Signals                     Direction  Beat payload
//   req      req_valid, req_ready, req   in         prq_pkg::req_t
//   rsp      rsp_valid, rsp_ready, rsp   out        prq_pkg::rsp_t
//
// An enqueue, or an unused request code, passes from the accept cycle through the
// finish state to the response register. A dequeue or purge first scans every
// held entry through the memory read port, then, when the entry at position P is
// removed, compacts the memory by moving each entry above P down one slot (no
// compaction on a miss). The single read port of the entry memory paces both the
// scan and the compaction.
// Reset clears the count and all control state; the memory needs no clearing
// because only slots below the count are ever read.
// A new request beat is taken only while the sequencer is idle. A finished
// result waits in the sequencer until the response register is free, so a
// stalled response holds back at most one further request.
module priority_ready_queue_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  prq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output prq_pkg::rsp_t  rsp
);
    import prq_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;     // next memory address to read
    logic              pend_reg, pend_next;   // a read is in flight
    logic [IDX_W-1:0]  pidx_reg, pidx_next;   // address of the read in flight
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    entry_t            best_reg, best_next;
    logic [1:0]        op_reg, op_next;
    logic [7:0]        key_reg, key_next;     // handle searched by a purge
    logic [1:0]        stat_reg, stat_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic              req_fire;
    logic              rsp_free;
    logic              issue_ok;

    prq_entry_store u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign issue_ok  = (iss_reg < count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        iss_next       = iss_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        stat_next      = stat_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        rd_addr        = iss_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_data        = '{handle: req.proc_handle, prio: req.priority_req};

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next    = req.req_type;
                    key_next   = req.proc_handle;
                    iss_next   = '0;
                    found_next = 1'b0;
                    stat_next  = STAT_MISS;
                    case (req.req_type)
                        REQ_ENQ:
                        begin
                            state_next = S_FINISH;
                            if (count_reg < CNT_W'(QUEUE_DEPTH))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                stat_next  = STAT_OK;
                            end
                            else
                            begin
                                stat_next = STAT_FULL;
                            end
                        end
                        REQ_DEQ, REQ_PURGE:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Reads stream out one per cycle; each returned entry is judged
                // against the best candidate so far.
                if (issue_ok)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = iss_reg[IDX_W-1:0];
                    iss_next  = iss_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (op_reg == REQ_DEQ)
                    begin
                        if (!found_reg || (rd_data.prio < best_reg.prio))
                        begin
                            found_next    = 1'b1;
                            best_idx_next = pidx_reg;
                            best_next     = rd_data;
                        end
                    end
                    else if (!found_reg && (rd_data.handle == key_reg))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = pidx_reg;
                        best_next     = rd_data;
                    end
                end
                if (!issue_ok && !pend_reg)
                begin
                    if (found_reg)
                    begin
                        state_next = S_SHIFT;
                        iss_next   = CNT_W'(best_idx_reg) + 1'b1;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_SHIFT:
            begin
                // Read slot i and write it to slot i - 1 in the next cycle; the
                // write always trails the read, so no forwarding is needed.
                if (issue_ok)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = iss_reg[IDX_W-1:0];
                    iss_next  = iss_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_reg - 1'b1;
                    wr_data = rd_data;
                end
                if (!issue_ok && !pend_reg)
                begin
                    count_next = count_reg - 1'b1;
                    stat_next  = STAT_OK;
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = stat_reg;
                    if ((stat_reg == STAT_OK) && (op_reg != REQ_ENQ))
                    begin
                        rsp_next.out_handle   = best_reg.handle;
                        rsp_next.out_priority = best_reg.prio;
                    end
                    else
                    begin
                        rsp_next.out_handle   = '0;
                        rsp_next.out_priority = '0;
                    end
                    rsp_next.entry_count = ENTRY_COUNT_W'(count_reg);
                    rsp_next.is_empty    = (count_reg == '0);
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        stat_reg     <= stat_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count never passes the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // A read in flight always targets a held slot.
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (CNT_W'(pidx_reg) < count_reg))
        else $error("memory read outside held slots");

    // Compaction only writes below the last held slot.
    a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg == S_SHIFT)) |-> (CNT_W'(wr_addr) + 1'b1 < count_reg))
        else $error("compaction write outside held slots");

    // A response is loaded only when the response register is free.
    a_rsp_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (state_reg != S_IDLE) || $stable(rsp))
        else $error("response overwritten while stalled");

endmodule
